>>> rtl/qasf_pkg.sv
// Shared types and constants of the quote-aware substring finder.
`default_nettype none

package qasf_pkg;

  localparam int BYTE_W        = 8;
  localparam int POS_W         = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int PLEN_W        = 5;
  localparam int PCNT_W        = 3;
  localparam int PATTERN_BYTES = 16;

  localparam logic [CFG_DATA_W-1:0] LIMITER_RESET = 64'h0000_0000_2727_2222;
  localparam logic [PLEN_W-1:0]     PLEN_RESET    = 5'd1;
  localparam logic [PCNT_W-1:0]     PCNT_RESET    = 3'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW    = 3'd0,
    REG_PATTERN_HIGH   = 3'd1,
    REG_PATTERN_LENGTH = 3'd2,
    REG_LIMITER_PAIRS  = 3'd3,
    REG_PAIR_COUNT     = 3'd4
  } qasf_reg_e;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] pattern_low;
    logic [CFG_DATA_W-1:0] pattern_high;
    logic [PLEN_W-1:0]     pattern_length;
    logic [CFG_DATA_W-1:0] limiter_pairs;
    logic [PCNT_W-1:0]     pair_count;
  } qasf_cfg_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] match_position;
  } qasf_res_t;

endpackage

`default_nettype wire

>>> rtl/qasf_intf.sv
// Handshake channel interfaces: text input, result output and register writes.
`default_nettype none

interface qasf_in_if import qasf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              first;
  logic              last;
  logic [POS_W-1:0]  base_index;

  modport source (output valid, data_byte, first, last, base_index, input ready);
  modport sink   (input valid, data_byte, first, last, base_index, output ready);
endinterface

interface qasf_out_if import qasf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [POS_W-1:0] match_position;

  modport source (output valid, found, match_position, input ready);
  modport sink   (input valid, found, match_position, output ready);
endinterface

interface qasf_cfg_if import qasf_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/quote_aware_substring_finder_top.sv
// Quote-aware substring finder: one text byte per cycle through a chain of window cells.
// Throughput: one byte per cycle; the chain shifts once per byte that is not dropped.
// A result is written into the result buffer when the byte that causes it is transferred.
// Input stalls only while both entries of the result buffer are occupied.
// Reset restores the register defaults and clears quote state, start flags and offset;
// no clearing pass is needed, so bytes are accepted straight after reset.
`default_nettype none

module quote_aware_substring_finder_top import qasf_pkg::*; #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_PAIRS   = 4,
  parameter int INDEX_BITS  = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  qasf_in_if.sink    in_i,
  qasf_out_if.source out_o,
  qasf_cfg_if.sink   cfg_i
);

  localparam int LenIdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int SumW    = ((INDEX_BITS > POS_W) ? INDEX_BITS : POS_W) + 1;
  localparam logic [SumW-1:0]  IdxMaxS  = SumW'((65'd1 << INDEX_BITS) - 65'd1);
  localparam logic [POS_W-1:0] BaseMask = (INDEX_BITS >= POS_W) ? '1 : IdxMaxS[POS_W-1:0];

  qasf_cfg_t cfg_q;

  // Register writes.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
      cfg_q.pattern_length <= PLEN_RESET;
      cfg_q.limiter_pairs  <= LIMITER_RESET;
      cfg_q.pair_count     <= PCNT_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PATTERN_LOW:    cfg_q.pattern_low    <= cfg_i.data;
        REG_PATTERN_HIGH:   cfg_q.pattern_high   <= cfg_i.data;
        REG_PATTERN_LENGTH: cfg_q.pattern_length <= cfg_i.data[PLEN_W-1:0];
        REG_LIMITER_PAIRS:  cfg_q.limiter_pairs  <= cfg_i.data;
        REG_PAIR_COUNT:     cfg_q.pair_count     <= cfg_i.data[PCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective pattern length, held within 1 and the cell count.
  logic [PLEN_W-1:0]            len_eff;
  logic [LenIdxW-1:0]           len_m1;
  logic [2*CFG_DATA_W-1:0]      pattern;

  assign len_eff = (cfg_q.pattern_length == '0) ? PLEN_W'(1) :
                   (cfg_q.pattern_length > PLEN_W'(MAX_PATTERN)) ? PLEN_W'(MAX_PATTERN) :
                   cfg_q.pattern_length;
  assign len_m1  = LenIdxW'(len_eff - PLEN_W'(1));
  assign pattern = {cfg_q.pattern_high, cfg_q.pattern_low};

  // Stream control.
  logic      accept, step, reported_q, push, match;
  qasf_res_t res;
  logic      buf_full;
  logic      quote_ok;

  assign in_i.ready = !buf_full;
  assign accept     = in_i.valid && in_i.ready;
  // Bytes after the result are dropped until the next string begins.
  assign step       = accept && (in_i.first || !reported_q);

  qasf_quote #(
    .MAX_PAIRS (MAX_PAIRS)
  ) u_quote (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .first_i (in_i.first),
    .byte_i  (in_i.data_byte),
    .cfg_i   (cfg_q),
    .ok_o    (quote_ok)
  );

  // Window cells, newest byte in cell 0.
  logic [BYTE_W-1:0]      win_byte [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] win_ok;
  logic [MAX_PATTERN-1:0] next_ok;
  logic [MAX_PATTERN-1:0] hit;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic [BYTE_W-1:0] nbr_byte;
    logic              nbr_ok;
    logic              flush;
    logic [3:0]        pat_idx;

    if (i == 0) begin : g_head
      assign nbr_byte = in_i.data_byte;
      assign nbr_ok   = quote_ok;
      assign flush    = 1'b0;
    end else begin : g_body
      assign nbr_byte = win_byte[i-1];
      assign nbr_ok   = win_ok[i-1];
      assign flush    = in_i.first;
    end

    // Cell i holds the byte that pattern byte len-1-i must equal.
    assign pat_idx = 4'(len_m1) - 4'(i);

    qasf_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (step),
      .flush_i    (flush),
      .nbr_byte_i (nbr_byte),
      .nbr_ok_i   (nbr_ok),
      .pat_byte_i (pattern[BYTE_W*pat_idx +: BYTE_W]),
      .en_i       (LenIdxW'(i) <= len_m1),
      .byte_o     (win_byte[i]),
      .ok_o       (win_ok[i]),
      .next_ok_o  (next_ok[i]),
      .hit_o      (hit[i])
    );
  end

  // Offset counter and base.
  logic [INDEX_BITS-1:0] offset_q, offset_d, off_cur;
  logic [POS_W-1:0]      base_q, base_cur;
  logic                  off_max;
  logic [SumW-1:0]       sum, pos;

  assign off_cur  = in_i.first ? '0 : offset_q;
  assign off_max  = &off_cur;
  assign offset_d = off_max ? off_cur : off_cur + INDEX_BITS'(1);
  assign base_cur = in_i.first ? (in_i.base_index & BaseMask) : base_q;

  assign sum = SumW'(base_cur) + SumW'(off_cur) - SumW'(len_m1);
  assign pos = (off_max || (sum > IdxMaxS)) ? IdxMaxS : sum;

  assign match = next_ok[len_m1] && (&hit);
  assign push  = step && (match || in_i.last);

  assign res.found          = match;
  assign res.match_position = match ? pos[POS_W-1:0] : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q   <= '0;
      base_q     <= '0;
      reported_q <= 1'b0;
    end else if (step) begin
      offset_q   <= offset_d;
      base_q     <= base_cur;
      reported_q <= push;
    end
  end

  qasf_res_t out_data;

  qasf_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (res),
    .full_o  (buf_full),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_data)
  );

  assign out_o.found          = out_data.found;
  assign out_o.match_position = out_data.match_position;

endmodule

`default_nettype wire

>>> rtl/qasf_cell.sv
// One window cell: holds a text byte and its start flag, compares the incoming byte.
`default_nettype none

module qasf_cell import qasf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              flush_i,
  input  wire logic [BYTE_W-1:0] nbr_byte_i,
  input  wire logic              nbr_ok_i,
  input  wire logic [BYTE_W-1:0] pat_byte_i,
  input  wire logic              en_i,
  output logic      [BYTE_W-1:0] byte_o,
  output logic                   ok_o,
  output logic                   next_ok_o,
  output logic                   hit_o
);

  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              ok_q, ok_d;

  // A new string empties the window behind the head cell.
  assign byte_d    = flush_i ? '0 : nbr_byte_i;
  assign ok_d      = flush_i ? 1'b0 : nbr_ok_i;
  assign next_ok_o = ok_d;
  assign hit_o     = !en_i || (byte_d == pat_byte_i);
  assign byte_o    = byte_q;
  assign ok_o      = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (step_i) begin
      ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      byte_q <= byte_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/qasf_quote.sv
// Quote tracker: follows opener and closer bytes and flags bytes that may start a match.
`default_nettype none

module qasf_quote import qasf_pkg::*; #(
  parameter int MAX_PAIRS = 4
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              first_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  input  wire qasf_cfg_t         cfg_i,
  output logic                   ok_o
);

  logic              in_quote_q, in_quote_d;
  logic [BYTE_W-1:0] closer_q, closer_d;
  logic              quoted;
  logic              opener;
  logic [BYTE_W-1:0] closer_new;
  logic [PCNT_W-1:0] pairs_eff;

  assign pairs_eff = (cfg_i.pair_count > PCNT_W'(MAX_PAIRS)) ? PCNT_W'(MAX_PAIRS)
                                                             : cfg_i.pair_count;

  always_comb begin
    quoted     = !first_i && in_quote_q;
    opener     = 1'b0;
    closer_new = '0;
    // The lowest pair wins when an opener appears in several pairs.
    for (int k = 0; k < MAX_PAIRS; k++) begin
      if (!opener && (PCNT_W'(k) < pairs_eff) &&
          (byte_i == cfg_i.limiter_pairs[16*k +: BYTE_W])) begin
        opener     = 1'b1;
        closer_new = cfg_i.limiter_pairs[16*k+8 +: BYTE_W];
      end
    end
    if (quoted) begin
      in_quote_d = (byte_i != closer_q);
      closer_d   = closer_q;
    end else begin
      in_quote_d = opener;
      closer_d   = opener ? closer_new : (first_i ? '0 : closer_q);
    end
  end

  assign ok_o = !quoted && !opener;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_quote_q <= 1'b0;
      closer_q   <= '0;
    end else if (step_i) begin
      in_quote_q <= in_quote_d;
      closer_q   <= closer_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/qasf_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module qasf_out_buf import qasf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire qasf_res_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  wire logic      ready_i,
  output qasf_res_t      data_o
);

  logic      out_valid_q, skid_valid_q;
  qasf_res_t out_data_q, skid_data_q;
  logic      pop;

  assign pop     = out_valid_q && ready_i;
  assign full_o  = skid_valid_q;
  assign valid_o = out_valid_q;
  assign data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (pop) begin
      if (skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!push_i) begin
        out_valid_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  // No push arrives while the skid register is full.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_data_q <= skid_data_q;
      end else if (push_i) begin
        out_data_q <= data_i;
      end
    end else if (push_i) begin
      if (!out_valid_q) begin
        out_data_q <= data_i;
      end else begin
        skid_data_q <= data_i;
      end
    end
  end

endmodule

`default_nettype wire

>>> test/quote_aware_substring_finder_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the quote-aware substring finder, with a built-in scan predictor.

module quote_aware_substring_finder_top_test import qasf_pkg::*; ();

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POS_MAX     = (1 << POS_W) - 1;
  localparam int RANDOM_BYTES_PER_PHASE = 415;

  typedef logic [BYTE_W-1:0] octet_t;
  typedef octet_t octet_q_t[$];

  logic clk_i;
  logic rst_ni;

  qasf_in_if  in_if ();
  qasf_out_if out_if ();
  qasf_cfg_if cfg_if ();

  quote_aware_substring_finder_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Register image, kept in step with every accepted register write.
  logic [CFG_DATA_W-1:0] cfg_pattern_lo  = '0;
  logic [CFG_DATA_W-1:0] cfg_pattern_hi  = '0;
  logic [PLEN_W-1:0]     cfg_pattern_len = PLEN_RESET;
  logic [CFG_DATA_W-1:0] cfg_limiters    = LIMITER_RESET;
  logic [PCNT_W-1:0]     cfg_pair_count  = PCNT_RESET;

  // Scan state of the string in progress.
  logic                     quote_open   = 1'b0;
  octet_t                   quote_closer = '0;
  octet_t                   text_window [PATTERN_BYTES];
  logic [PATTERN_BYTES-1:0] start_flags  = '0;
  logic [POS_W-1:0]         scan_offset  = '0;
  logic [POS_W-1:0]         scan_base    = '0;
  logic                     string_done  = 1'b0;

  qasf_res_t expected_hits[$];
  qasf_res_t due;
  int        scanned_bytes = 0;
  int        mismatches    = 0;
  int        cycle_count   = 0;
  int        send_idle_pct = 0;
  int        stall_pct     = 0;

  octet_t byte_pool [6] = '{8'h61, 8'h62, 8'h63, 8'h22, 8'h27, 8'h28};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  function automatic int active_length();
    int n;
    n = cfg_pattern_len;
    if (n < 1) n = 1;
    if (n > PATTERN_BYTES) n = PATTERN_BYTES;
    return n;
  endfunction

  function automatic int active_pairs();
    return (cfg_pair_count > 4) ? 4 : int'(cfg_pair_count);
  endfunction

  function automatic octet_t pattern_byte(int j);
    logic [2*CFG_DATA_W-1:0] both;
    both = {cfg_pattern_hi, cfg_pattern_lo};
    return both[8*j +: 8];
  endfunction

  // Advances the scan by one byte and queues the result that byte gives, if any.
  function automatic void scan_text_byte(octet_t b, logic first, logic last,
                                         logic [POS_W-1:0] base);
    int        off;
    int        len;
    int        pos;
    logic      ok;
    logic      is_opener;
    logic      hit;
    qasf_res_t res;
    if (first) begin
      quote_open = 1'b0;
      quote_closer = '0;
      foreach (text_window[i]) text_window[i] = '0;
      start_flags = '0;
      scan_offset = '0;
      string_done = 1'b0;
      scan_base = base;
    end else if (string_done) begin
      return;
    end
    scanned_bytes++;
    off = scan_offset;
    if (scan_offset != POS_MAX[POS_W-1:0]) scan_offset++;
    ok = 1'b0;
    if (quote_open) begin
      if (b == quote_closer) quote_open = 1'b0;
    end else begin
      is_opener = 1'b0;
      // The lowest pair whose opener matches decides the closer.
      for (int k = 0; k < active_pairs(); k++) begin
        if (!is_opener && b == cfg_limiters[16*k +: 8]) begin
          quote_closer = cfg_limiters[16*k+8 +: 8];
          quote_open = 1'b1;
          is_opener = 1'b1;
        end
      end
      ok = !is_opener;
    end
    for (int i = PATTERN_BYTES - 1; i > 0; i--) text_window[i] = text_window[i-1];
    text_window[0] = b;
    start_flags = {start_flags[PATTERN_BYTES-2:0], ok};
    len = active_length();
    hit = start_flags[len-1];
    for (int j = 0; j < len; j++) begin
      if (text_window[len-1-j] != pattern_byte(j)) hit = 1'b0;
    end
    if (hit) begin
      if (off >= POS_MAX) pos = POS_MAX;
      else pos = int'(scan_base) + off - (len - 1);
      if (pos > POS_MAX) pos = POS_MAX;
      res.found = 1'b1;
      res.match_position = pos[POS_W-1:0];
      string_done = 1'b1;
      expected_hits.push_back(res);
    end else if (last) begin
      res.found = 1'b0;
      res.match_position = '0;
      string_done = 1'b1;
      expected_hits.push_back(res);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("mismatch in %s: got %0d, expected %0d (cycle %0d)", what, got, want,
             cycle_count);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result with none pending, found", out_if.found, 0);
      end else begin
        due = expected_hits.pop_front();
        if (out_if.found !== due.found)
          report_mismatch("found", out_if.found, due.found);
        if (out_if.match_position !== due.match_position)
          report_mismatch("match_position", out_if.match_position, due.match_position);
      end
    end
  end

  // Every task below is entered and left just after a falling edge.
  task automatic send_byte(octet_t b, logic first, logic last, logic [POS_W-1:0] base);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.first      <= first;
    in_if.last       <= last;
    in_if.base_index <= base;
    do @(posedge clk_i); while (!in_if.ready);
    scan_text_byte(b, first, last, base);
    @(negedge clk_i);
  endtask

  task automatic send_text(octet_q_t text, logic [POS_W-1:0] base, bit mark_first,
                           bit mark_last, bit scramble);
    logic f;
    logic l;
    for (int i = 0; i < text.size(); i++) begin
      f = scramble ? 1'($urandom_range(0, 1)) : (mark_first && i == 0);
      l = scramble ? 1'($urandom_range(0, 1)) : (mark_last && i == text.size() - 1);
      send_byte(text[i], f, l, f ? base : POS_W'($urandom_range(0, POS_MAX)));
    end
  endtask

  // Stops the input and waits until every pending result has been transferred.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_hits.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(qasf_reg_e idx, logic [CFG_DATA_W-1:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_PATTERN_LOW:    cfg_pattern_lo = value;
      REG_PATTERN_HIGH:   cfg_pattern_hi = value;
      REG_PATTERN_LENGTH: cfg_pattern_len = value[PLEN_W-1:0];
      REG_LIMITER_PAIRS:  cfg_limiters = value;
      REG_PAIR_COUNT:     cfg_pair_count = value[PCNT_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic octet_q_t text_of(string s);
    octet_q_t q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  function automatic octet_t pool_or_random();
    if ($urandom_range(0, 3) == 0) return octet_t'($urandom_range(0, 255));
    return byte_pool[$urandom_range(0, 5)];
  endfunction

  task automatic randomize_setup();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] lim;
    octet_t                op;
    int                    len;
    int                    cnt;
    int                    r;
    for (int j = 0; j < 8; j++) begin
      lo[8*j +: 8] = pool_or_random();
      hi[8*j +: 8] = pool_or_random();
    end
    if ($urandom_range(0, 5) == 0) lo = {$urandom, $urandom};
    if ($urandom_range(0, 5) == 0) hi = {$urandom, $urandom};
    r = $urandom_range(0, 19);
    if (r == 0) len = $urandom_range(0, 1) ? 0 : $urandom_range(17, 31);
    else if (r < 4) len = $urandom_range(5, 16);
    else len = $urandom_range(1, 4);
    for (int k = 0; k < 4; k++) begin
      op = pool_or_random();
      lim[16*k +: 8] = op;
      lim[16*k+8 +: 8] = ($urandom_range(0, 2) == 0) ? op : pool_or_random();
    end
    if ($urandom_range(0, 7) == 0) lim = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) begin
      cnt = $urandom_range(0, 3);
      if (cnt != 0) cnt = cnt + 4;
    end else begin
      cnt = $urandom_range(1, 4);
    end
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
    write_reg(REG_LIMITER_PAIRS, lim);
    write_reg(REG_PAIR_COUNT, CFG_DATA_W'(cnt));
  endtask

  // Bytes before any string start run from the reset state; later bytes are ignored.
  task automatic test_reset_state();
    send_byte(8'h00, 1'b0, 1'b0, 16'hFFFF);
    send_byte(8'hFF, 1'b0, 1'b1, 16'h0000);
    wait_idle();
  endtask

  task automatic test_quote_regions();
    write_reg(REG_PATTERN_LOW, 64'h6261);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    send_text(text_of("\"ab\"ab"), 16'd100, 1'b1, 1'b1, 1'b0);
    wait_idle();
    // An opener as start byte never matches, and its quote hides the rest.
    write_reg(REG_PATTERN_LOW, 64'h7127);
    send_text(text_of("x'q!"), 16'd7, 1'b1, 1'b1, 1'b0);
    wait_idle();
    // Two pairs share an opener; the closer of the lower pair ends the quote.
    write_reg(REG_LIMITER_PAIRS, 64'h5D28_2928);
    write_reg(REG_PATTERN_LOW, 64'h7A);
    write_reg(REG_PATTERN_LENGTH, 64'd1);
    send_text(text_of("(z]z)z"), 16'd0, 1'b1, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_PAIR_COUNT, 64'd0);
    write_reg(REG_PATTERN_LOW, 64'h28);
    send_text(text_of("x("), 16'd20, 1'b1, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_PAIR_COUNT, 64'd7);
    write_reg(REG_LIMITER_PAIRS, 64'h2323_0000_0000_0000);
    write_reg(REG_PATTERN_LOW, 64'h23);
    send_text(text_of("#a#"), 16'd3, 1'b1, 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    octet_q_t text;
    write_reg(REG_LIMITER_PAIRS, LIMITER_RESET);
    write_reg(REG_PAIR_COUNT, CFG_DATA_W'(PCNT_RESET));
    // A zero length counts as one; match and last fall on the same byte.
    write_reg(REG_PATTERN_LOW, 64'hFF);
    write_reg(REG_PATTERN_LENGTH, 64'd0);
    send_byte(8'hFF, 1'b1, 1'b1, 16'hFFFF);
    wait_idle();
    // The base plus offset runs past the top and saturates.
    write_reg(REG_PATTERN_LOW, 64'h00FF);
    write_reg(REG_PATTERN_LENGTH, 64'd2);
    text = {8'h11, 8'hFF, 8'h00};
    send_text(text, 16'hFFFF, 1'b1, 1'b1, 1'b0);
    wait_idle();
    // A length above the maximum counts as a full pattern, longer than the string.
    write_reg(REG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PATTERN_LENGTH, 64'd31);
    send_text(text_of("ab\"c'"), 16'd9, 1'b1, 1'b1, 1'b0);
    wait_idle();
  endtask

  task automatic test_random_text(int idle_pct, int stall, int budget);
    octet_q_t         text;
    logic [POS_W-1:0] base;
    int               n;
    int               r;
    int               k;
    int               plan;
    int               stop_at;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    wait_idle();
    randomize_setup();
    stop_at = scanned_bytes + budget;
    while (scanned_bytes < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        wait_idle();
        randomize_setup();
      end else if ($urandom_range(0, 29) == 0) begin
        wait_idle();
      end
      text.delete();
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 20);
      while (text.size() < n) begin
        r = $urandom_range(0, 9);
        k = $urandom_range(0, 3);
        if (r == 0) begin
          for (int j = 0; j < active_length(); j++) text.push_back(pattern_byte(j));
        end else if (r < 5) begin
          text.push_back(pattern_byte($urandom_range(0, active_length() - 1)));
        end else if (r < 7) begin
          text.push_back(cfg_limiters[16*k +: 8]);
        end else if (r == 7) begin
          text.push_back(cfg_limiters[16*k+8 +: 8]);
        end else begin
          text.push_back(octet_t'($urandom_range(0, 255)));
        end
      end
      if ($urandom_range(0, 7) == 0) base = POS_W'(POS_MAX - $urandom_range(0, 40));
      else base = POS_W'($urandom_range(0, POS_MAX));
      // Mostly well-formed strings; a few lose their start or end, or get random flags.
      plan = $urandom_range(0, 19);
      send_text(text, base, plan != 0, plan != 1, plan == 2);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.data_byte = '0;
    in_if.first = 1'b0;
    in_if.last = 1'b0;
    in_if.base_index = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    foreach (text_window[i]) text_window[i] = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_state();
    test_quote_regions();
    test_register_extremes();
    test_random_text(0, 0, RANDOM_BYTES_PER_PHASE);
    test_random_text(59, 0, RANDOM_BYTES_PER_PHASE);
    test_random_text(0, 59, RANDOM_BYTES_PER_PHASE);
    test_random_text(19, 19, RANDOM_BYTES_PER_PHASE);
    wait_idle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
